// File: sv/jsew_pkg.sv
// jsew_pkg: shared types and constants for the JSON string escape writer.
// No dependencies; used by every module of the block.
`default_nettype none

package jsew_pkg;

  localparam int unsigned POS_W   = 21;
  localparam int unsigned SEQ_MAX = 6;
  localparam int unsigned LEN_W   = 3;
  localparam int unsigned IDX_W   = 3;

  localparam logic [POS_W-1:0] CAP_RESET = 21'd4096;

  localparam logic [2:0] OP_ESC    = 3'd0;
  localparam logic [2:0] OP_RAW    = 3'd1;
  localparam logic [2:0] OP_QUOTE  = 3'd2;
  localparam logic [2:0] OP_NULL   = 3'd3;
  localparam logic [2:0] OP_NEWBUF = 3'd4;

  typedef struct packed {
    logic [2:0] operation;
    logic [7:0] data_byte;
  } in_word_t;

  typedef struct packed {
    logic [7:0]       out_byte;
    logic             byte_valid;
    logic             last_of_run;
    logic             overflow;
    logic [POS_W-1:0] position;
  } out_word_t;

  // One classified item: either a byte run to emit or a single status word.
  typedef struct packed {
    logic [SEQ_MAX-1:0][7:0] seq;
    logic [LEN_W-1:0]        len;
    logic                    wr;
    logic                    ovf;
    logic [POS_W-1:0]        pos;  // base position for runs, final for status
  } job_t;

  function automatic logic [7:0] hex_digit(input logic [3:0] v);
    logic [7:0] r;
    if (v < 4'd10) begin
      r = 8'h30 + {4'd0, v};
    end else begin
      r = 8'h61 + {4'd0, v} - 8'd10;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// File: sv/jsew_front.sv
// jsew_front: accepts items, builds the escape sequence, checks capacity and
// keeps write position, overflow flag and capacity. Depends on jsew_pkg.
`default_nettype none

module jsew_front (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    accept,
  input  wire jsew_pkg::in_word_t      in_word,
  input  wire logic                    cfg_wr_en,
  input  wire logic [jsew_pkg::POS_W-1:0] cfg_data,
  output jsew_pkg::job_t               job
);

  logic [jsew_pkg::POS_W-1:0] pos_r, pos_nxt;
  logic                       ovf_r, ovf_nxt;
  logic [jsew_pkg::POS_W-1:0] cap_r;

  logic [jsew_pkg::SEQ_MAX-1:0][7:0] seq;
  logic [jsew_pkg::LEN_W-1:0]        len;
  logic                              is_write;
  logic [jsew_pkg::POS_W:0]          end_pos;
  logic [7:0]                        c;

  always_comb begin
    c        = in_word.data_byte;
    seq      = '0;
    len      = jsew_pkg::LEN_W'(1);
    is_write = 1'b1;
    case (in_word.operation)
      jsew_pkg::OP_ESC: begin
        seq[0] = 8'h5c;
        len    = jsew_pkg::LEN_W'(2);
        if (c == 8'h22 || c == 8'h5c) begin
          seq[1] = c;
        end else if (c == 8'h0a) begin
          seq[1] = 8'h6e;
        end else if (c == 8'h0d) begin
          seq[1] = 8'h72;
        end else if (c == 8'h09) begin
          seq[1] = 8'h74;
        end else if (c < 8'h20) begin
          seq[1] = 8'h75;
          seq[2] = 8'h30;
          seq[3] = 8'h30;
          seq[4] = jsew_pkg::hex_digit(c[7:4]);
          seq[5] = jsew_pkg::hex_digit(c[3:0]);
          len    = jsew_pkg::LEN_W'(6);
        end else begin
          seq[0] = c;
          len    = jsew_pkg::LEN_W'(1);
        end
      end
      jsew_pkg::OP_RAW: begin
        seq[0] = c;
      end
      jsew_pkg::OP_QUOTE: begin
        seq[0] = 8'h22;
      end
      jsew_pkg::OP_NULL: begin
        seq[0] = 8'h6e;
        seq[1] = 8'h75;
        seq[2] = 8'h6c;
        seq[3] = 8'h6c;
        len    = jsew_pkg::LEN_W'(4);
      end
      default: begin
        is_write = 1'b0;
      end
    endcase
  end

  assign end_pos = {1'b0, pos_r} + (jsew_pkg::POS_W + 1)'(len);

  always_comb begin
    pos_nxt = pos_r;
    ovf_nxt = ovf_r;
    job.seq = seq;
    job.len = len;
    job.wr  = 1'b0;
    if (in_word.operation == jsew_pkg::OP_NEWBUF) begin
      pos_nxt = '0;
      ovf_nxt = 1'b0;
    end else if (is_write && !ovf_r) begin
      if (end_pos > {1'b0, cap_r}) begin
        ovf_nxt = 1'b1;
      end else begin
        pos_nxt = end_pos[jsew_pkg::POS_W-1:0];
        job.wr  = 1'b1;
      end
    end
    job.ovf = ovf_nxt;
    job.pos = job.wr ? pos_r : pos_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
      ovf_r <= 1'b0;
      cap_r <= jsew_pkg::CAP_RESET;
    end else begin
      if (accept) begin
        pos_r <= pos_nxt;
        ovf_r <= ovf_nxt;
      end
      if (cfg_wr_en) begin
        cap_r <= cfg_data;
      end
    end
  end

endmodule

`default_nettype wire

// File: sv/jsew_queue.sv
// jsew_queue: short job queue between front and back end.
// Depends on jsew_pkg for the job type.
`default_nettype none

module jsew_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           wr_en,
  input  wire jsew_pkg::job_t wr_job,
  output logic                full,
  input  wire logic           rd_en,
  output jsew_pkg::job_t      rd_job,
  output logic                empty
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  jsew_pkg::job_t   store_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  assign full   = (cnt_r == CNT_W'(DEPTH));
  assign empty  = (cnt_r == '0);
  assign rd_job = store_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (wr_en && !rd_en) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (!wr_en && rd_en) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      store_r[wr_ptr_r] <= wr_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr_r <= ptr_inc(wr_ptr_r);
      end
      if (rd_en) begin
        rd_ptr_r <= ptr_inc(rd_ptr_r);
      end
      cnt_r <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire

// File: sv/jsew_back.sv
// jsew_back: walks the job at the queue head and presents one result word
// per byte, or one status word. Depends on jsew_pkg.
`default_nettype none

module jsew_back (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire jsew_pkg::job_t job,
  input  wire logic           job_empty,
  output logic                job_done,
  output logic                empty,
  input  wire logic           pop,
  output jsew_pkg::out_word_t out_word
);

  logic [jsew_pkg::IDX_W-1:0] idx_r, idx_nxt;
  logic                       last;
  logic                       take;

  assign empty    = job_empty;
  assign take     = pop && !job_empty;
  assign last     = !job.wr || (idx_nxt == jsew_pkg::IDX_W'(job.len));
  assign job_done = take && last;
  assign idx_nxt  = idx_r + jsew_pkg::IDX_W'(1);

  always_comb begin
    out_word.byte_valid  = job.wr;
    out_word.last_of_run = last;
    out_word.overflow    = job.ovf;
    if (job.wr) begin
      out_word.out_byte = job.seq[idx_r];
      out_word.position = job.pos + jsew_pkg::POS_W'(idx_nxt);
    end else begin
      out_word.out_byte = 8'h00;
      out_word.position = job.pos;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
    end else if (take) begin
      idx_r <= last ? '0 : idx_nxt;
    end
  end

endmodule

`default_nettype wire

// File: sv/json_string_escape_writer_unit.sv
// json_string_escape_writer_unit: top level of the JSON string escape writer.
// Instantiates jsew_front, jsew_queue and jsew_back; depends on jsew_pkg.
//
//   channel   ports                     dir   accepted when
//   input     push, full, in_word       in    push && !full
//   result    empty, pop, out_word      out   pop && !empty
//   config    cfg_wr_en, cfg_data       in    cfg_wr_en
//
// An item enters the queue when accepted; the back end emits one word per
// cycle while pop is held and a job waits, so an item with n result words
// (1 to 6) takes n pops. One-word items flow back to back at one per cycle
// while push and pop are held. full rises when QUEUE_DEPTH jobs wait; the
// front then stalls until a job completes. Reset is synchronous: position 0,
// overflow clear, capacity 4096, queue empty.
`default_nettype none

module json_string_escape_writer_unit #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       push,
  output logic                            full,
  input  wire jsew_pkg::in_word_t         in_word,
  output logic                            empty,
  input  wire logic                       pop,
  output jsew_pkg::out_word_t             out_word,
  input  wire logic                       cfg_wr_en,
  input  wire logic [jsew_pkg::POS_W-1:0] cfg_data
);

  logic           accept;
  jsew_pkg::job_t new_job;
  jsew_pkg::job_t head_job;
  logic           q_empty;
  logic           job_done;

  assign accept = push && !full;

  jsew_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .in_word   (in_word),
    .cfg_wr_en (cfg_wr_en),
    .cfg_data  (cfg_data),
    .job       (new_job)
  );

  jsew_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr_en  (accept),
    .wr_job (new_job),
    .full   (full),
    .rd_en  (job_done),
    .rd_job (head_job),
    .empty  (q_empty)
  );

  jsew_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job       (head_job),
    .job_empty (q_empty),
    .job_done  (job_done),
    .empty     (empty),
    .pop       (pop),
    .out_word  (out_word)
  );

endmodule

`default_nettype wire
